// ----- design/mpct_pkg.sv -----
// Shared types and constants for the mouse packet cursor tracker.
// No dependencies; compile first.
`timescale 1ns / 1ps

package mpct_pkg;

	localparam int unsigned COORD_W = 10;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 1'b1;

	localparam logic [COORD_W-1:0] X_LIMIT_RST = 10'd319;
	localparam logic [COORD_W-1:0] Y_LIMIT_RST = 10'd239;
	localparam logic [COORD_W-1:0] POS_X_RST   = 10'd160;
	localparam logic [COORD_W-1:0] POS_Y_RST   = 10'd120;

	// ceil(2^10 / 5): exact quotient for magnitudes up to 128
	localparam logic [7:0] DIV5_RECIP = 8'd205;
	localparam int unsigned DIV5_SHIFT = 10;

	// Where the next byte lands in the three-byte packet
	typedef enum logic [1:0] {
		POS_STATUS = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} byte_pos_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] cursor_x;
		logic [COORD_W-1:0] cursor_y;
		logic               button_pressed;
	} cursor_word_t;

endpackage

// ----- design/mpct_if.sv -----
// Valid/ready stream interfaces for received mouse bytes and cursor results.
// Depends on mpct_pkg.
`timescale 1ns / 1ps

interface mpct_rx_if import mpct_pkg::*; ();
	logic     valid;
	logic     ready;
	rx_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mpct_cursor_if import mpct_pkg::*; ();
	logic         valid;
	logic         ready;
	cursor_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/mouse_packet_cursor_tracker.sv -----
// Top level of the mouse packet cursor tracker: byte framing, motion scaling,
// clamped cursor update. Depends on mpct_pkg and the stream interfaces in mpct_if.
`timescale 1ns / 1ps

// Accepts one received mouse byte per word on rx and groups every three words
// into a packet (status, X motion, Y motion); framing comes from a byte count
// only, with no status-bit resynchronization. On the Y byte both motion bytes are
// taken as signed, divided by 5 toward zero, added to the held cursor position and
// clamped to 0..x_limit / 0..y_limit, and one word goes out on cursor with the new
// position and the left-button bit. The block takes one byte per cycle while no Y
// byte waits on a stalled cursor: a byte is held in the input register, and the
// packet math is combinational between that register and the output register, so
// a Y byte's result is loaded into the output register as the byte leaves the
// input register. The output register holds a result while cursor is stalled;
// status and X bytes still pass through meanwhile, and only a Y byte waits for the
// output register to free up. The user must write limits via cfg_we/cfg_index/
// cfg_data only while idle; the block does not enforce it. Limits take effect at
// the next completed packet, where the held position is clamped even if the
// motion is zero. Reset position is 160,120 and reset limits are 319,239.
module mouse_packet_cursor_tracker import mpct_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	mpct_rx_if.sink              rx,
	mpct_cursor_if.source        cursor
);

	// Configuration
	logic [COORD_W-1:0] x_limit_q;
	logic [COORD_W-1:0] y_limit_q;

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	// Packet state
	byte_pos_t          pos_q;
	byte_pos_t          pos_d;
	logic [BYTE_W-1:0]  status_q;
	logic [BYTE_W-1:0]  x_motion_q;
	logic [COORD_W-1:0] pos_x_q;
	logic [COORD_W-1:0] pos_y_q;

	// Output register
	logic               out_valid_q;
	logic [COORD_W-1:0] cursor_x_q;
	logic [COORD_W-1:0] cursor_y_q;
	logic               button_q;

	logic               out_free;
	logic               is_y_byte;
	logic               s1_go;
	logic               emit;
	logic [COORD_W-1:0] next_x;
	logic [COORD_W-1:0] next_y;

	// Signed byte divided by 5, truncated toward zero: -25..25.
	function automatic logic signed [COORD_W:0] scale_motion(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0]  mag;
		logic [14:0]        prod;
		logic [COORD_W:0]   quo;
		begin
			mag  = b[BYTE_W-1] ? BYTE_W'(-b) : b;
			prod = 15'(mag) * 15'(DIV5_RECIP);
			quo  = (COORD_W+1)'(prod >> DIV5_SHIFT);
			return b[BYTE_W-1] ? $signed(-quo) : $signed(quo);
		end
	endfunction

	// Add motion to a coordinate and clamp to 0..limit.
	function automatic logic [COORD_W-1:0] move_clamped(
		input logic [COORD_W-1:0]        pos,
		input logic signed [COORD_W:0]   delta,
		input logic [COORD_W-1:0]        limit
	);
		logic signed [COORD_W+1:0] sum;
		begin
			sum = $signed({2'b00, pos}) + (COORD_W+2)'(delta);
			if (sum < 0) begin
				return '0;
			end else if (sum[COORD_W:0] > {1'b0, limit}) begin
				return limit;
			end else begin
				return sum[COORD_W-1:0];
			end
		end
	endfunction

	// Hold limits; the user must write them only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= X_LIMIT_RST;
			y_limit_q <= Y_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_LIMIT: x_limit_q <= cfg_data;
				CFG_Y_LIMIT: y_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Status and X bytes drain at once; a Y byte needs room at the output.
	assign out_free  = !out_valid_q || cursor.ready;
	assign is_y_byte = (pos_q == POS_Y);
	assign s1_go     = valid_s1 && (!is_y_byte || out_free);
	assign emit      = s1_go && is_y_byte;
	assign rx.ready  = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.data.rx_byte;
		end
	end

	// Next byte slot; the unused code is handled like status and moves on to X.
	always_comb begin
		pos_d = pos_q;
		if (s1_go) begin
			unique case (pos_q)
				POS_STATUS: pos_d = POS_X;
				POS_X:      pos_d = POS_Y;
				POS_Y:      pos_d = POS_STATUS;
				default:    pos_d = POS_X;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_STATUS;
		end else begin
			pos_q <= pos_d;
		end
	end

	assign next_x = move_clamped(pos_x_q, scale_motion(x_motion_q), x_limit_q);
	assign next_y = move_clamped(pos_y_q, scale_motion(rx_byte_s1), y_limit_q);

	// Store packet bytes and advance the cursor on the Y byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= '0;
			x_motion_q <= '0;
			pos_x_q    <= POS_X_RST;
			pos_y_q    <= POS_Y_RST;
		end else if (s1_go) begin
			priority case (pos_q)
				POS_X: x_motion_q <= rx_byte_s1;
				POS_Y: begin
					pos_x_q <= next_x;
					pos_y_q <= next_y;
				end
				default: status_q <= rx_byte_s1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cursor_x_q <= next_x;
			cursor_y_q <= next_y;
			button_q   <= status_q[0];
		end
	end

	assign cursor.valid               = out_valid_q;
	assign cursor.data.cursor_x       = cursor_x_q;
	assign cursor.data.cursor_y       = cursor_y_q;
	assign cursor.data.button_pressed = button_q;

	// A completed packet always lands in the output register.
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("completed packet did not reach output register");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cursor.ready) |-> !emit)
		else $error("result overwritten while stalled");

	// Framing returns to the status slot after each packet.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pos_q == POS_STATUS))
		else $error("byte position did not wrap after packet");

	// An empty input register always takes a byte.
	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("input stalled with empty input register");

	// The cursor position stays within the limits after a packet.
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (pos_x_q <= $past(x_limit_q)) && (pos_y_q <= $past(y_limit_q)))
		else $error("cursor position exceeds limit");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the mouse packet cursor tracker.
// Depends on mpct_pkg, the stream interfaces in mpct_if and the tracker top level.
`timescale 1ns / 1ps

module tb_top;
	import mpct_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_START = 1250;  // accepted bytes before the long cursor stall
	localparam int STALL_LEN   = 200;
	localparam int DRAIN_WAIT  = 5;     // settling margin after every owed cursor word is out

	// Idle patterns: who drops valid/ready and how often (percent of cycles)
	typedef enum int {PACE_SINK_HEAVY, PACE_SOURCE_HEAVY, PACE_FULL} pace_t;
	// Direction of the motion bytes in a generated packet
	typedef enum int {DRIFT_ANY, DRIFT_UP, DRIFT_DOWN} drift_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	mpct_rx_if     rx_ch ();
	mpct_cursor_if cursor_ch ();

	mouse_packet_cursor_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.cursor    (cursor_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: framing, held bytes, position and limits
	byte_pos_t          frame_pos;
	logic [7:0]         held_status;
	logic [7:0]         held_x_motion;
	logic [COORD_W-1:0] track_x;
	logic [COORD_W-1:0] track_y;
	logic [COORD_W-1:0] x_bound;
	logic [COORD_W-1:0] y_bound;

	logic [7:0]   byte_queue[$];       // bytes still to be offered on rx
	cursor_word_t expected_cursor[$];  // cursor words owed by the block

	pace_t pace;
	int    bytes_pushed;
	int    bytes_accepted;
	int    mismatches;
	int    cycle_count;
	int    stall_left;
	bit    stall_done;

	// Signed byte over five, truncating toward zero (SV division already does)
	function automatic int signed motion_step(logic [7:0] b);
		int signed v;
		v = int'($signed(b));
		return v / 5;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_move(logic [COORD_W-1:0] pos, int signed delta,
			logic [COORD_W-1:0] bound);
		int signed sum;
		sum = int'(pos) + delta;
		if (sum < 0)
			sum = 0;
		if (sum > int'(bound))
			return bound;
		return sum[COORD_W-1:0];
	endfunction

	// Advance the shadow framing by one accepted byte; the Y byte owes a cursor word
	task automatic track_byte(logic [7:0] b);
		cursor_word_t w;
		case (frame_pos)
			POS_X: begin
				held_x_motion = b;
				frame_pos = POS_Y;
			end
			POS_Y: begin
				track_x = clamp_move(track_x, motion_step(held_x_motion), x_bound);
				track_y = clamp_move(track_y, motion_step(b), y_bound);
				w.cursor_x = track_x;
				w.cursor_y = track_y;
				w.button_pressed = held_status[0];
				expected_cursor.push_back(w);
				frame_pos = POS_STATUS;
			end
			default: begin
				// status slot, and the unused code falls back here too
				held_status = b;
				frame_pos = POS_X;
			end
		endcase
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	function automatic int source_idle_pct(pace_t p);
		case (p)
			PACE_SINK_HEAVY:   return 6;
			PACE_SOURCE_HEAVY: return 58;
			default:           return 0;
		endcase
	endfunction

	function automatic int sink_idle_pct(pace_t p);
		case (p)
			PACE_SINK_HEAVY:   return 58;
			PACE_SOURCE_HEAVY: return 6;
			default:           return 0;
		endcase
	endfunction

	// Driver: hold the word while stalled, otherwise offer the next byte or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				track_byte(rx_ch.data.rx_byte);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (rx_ch.valid && !rx_ch.ready) begin
				// hold valid and data until the block takes the word
			end else if (byte_queue.size() != 0 &&
					$urandom_range(0, 99) >= source_idle_pct(pace)) begin
				rx_ch.valid <= 1'b1;
				rx_ch.data.rx_byte <= byte_queue.pop_front();
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Long cursor stall: starve the output so the block backs up into rx
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_done && bytes_accepted >= STALL_START) begin
			stall_left <= STALL_LEN;
			stall_done <= 1'b1;
		end
	end

	// Monitor: compare each delivered cursor word with the oldest one owed
	always @(posedge clk) begin
		cursor_word_t want;
		if (arst_n) begin
			if (cursor_ch.valid && cursor_ch.ready) begin
				if (expected_cursor.size() == 0) begin
					report_mismatch("cursor word with none owed, cursor_x",
						int'(cursor_ch.data.cursor_x), -1);
				end else begin
					want = expected_cursor.pop_front();
					if (cursor_ch.data.cursor_x !== want.cursor_x)
						report_mismatch("cursor_x", int'(cursor_ch.data.cursor_x),
							int'(want.cursor_x));
					if (cursor_ch.data.cursor_y !== want.cursor_y)
						report_mismatch("cursor_y", int'(cursor_ch.data.cursor_y),
							int'(want.cursor_y));
					if (cursor_ch.data.button_pressed !== want.button_pressed)
						report_mismatch("button_pressed",
							int'(cursor_ch.data.button_pressed),
							int'(want.button_pressed));
				end
			end
			cursor_ch.ready <= (stall_left == 0) &&
				($urandom_range(0, 99) >= sink_idle_pct(pace));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Write one limit register; only called while the block is drained
	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_X_LIMIT)
			x_bound = value;
		else
			y_bound = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every byte is taken and every owed word has come out
	task automatic wait_drained();
		while (bytes_accepted != bytes_pushed || expected_cursor.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic push_byte(logic [7:0] b);
		byte_queue.push_back(b);
		bytes_pushed++;
	endtask

	task automatic push_packet(logic [7:0] status, logic [7:0] dx, logic [7:0] dy);
		push_byte(status);
		push_byte(dx);
		push_byte(dy);
	endtask

	// Motion byte with a chosen sign, extremes mixed in now and then
	function automatic logic [7:0] pick_motion(drift_t d);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0:       return 8'h7F;
				1:       return 8'h80;
				2:       return 8'h00;
				default: return 8'hFF;
			endcase
		end
		case (d)
			DRIFT_UP:   return 8'($urandom_range(0, 127));
			DRIFT_DOWN: return 8'($urandom_range(128, 255));
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [COORD_W-1:0] lim_x;
		logic [COORD_W-1:0] lim_y;
		drift_t             drift;
		drift_t             dir_x;
		drift_t             dir_y;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_X_LIMIT;
		cfg_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.data = '0;
		cursor_ch.ready = 1'b0;
		pace = PACE_SINK_HEAVY;
		bytes_pushed = 0;
		bytes_accepted = 0;
		mismatches = 0;
		cycle_count = 0;
		stall_left = 0;
		stall_done = 1'b0;

		frame_pos = POS_STATUS;
		held_status = '0;
		held_x_motion = '0;
		track_x = POS_X_RST;
		track_y = POS_Y_RST;
		x_bound = X_LIMIT_RST;
		y_bound = Y_LIMIT_RST;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: keep the reset column bound, pull the row bound under the reset row
		// so the first packet clamps it even with zero motion.
		write_limit(CFG_Y_LIMIT, 10'd50);
		@(negedge clk);
		push_packet(8'h00, 8'h00, 8'h00);  // zero motion, row clamps to its bound
		push_packet(8'hFF, 8'h7F, 8'h80);  // largest step both ways
		push_packet(8'h01, 8'h81, 8'h81);  // -127 truncates to -25, row hits zero
		push_packet(8'hFE, 8'hFB, 8'hFC);  // -5 gives -1, -4 gives 0
		push_packet(8'h09, 8'h05, 8'h04);  // resync bit set, framing ignores it
		push_packet(8'h08, 8'hFF, 8'h7F);  // -1 gives 0
		push_packet(8'hC1, 8'h7F, 8'h7F);
		push_packet(8'h3E, 8'h7F, 8'h7F);  // row pinned at its bound
		wait_drained();

		// Random phases, each under its own pair of limits and drift
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin lim_x = 10'd0;    lim_y = 10'd0;    drift = DRIFT_ANY;  end
				1: begin lim_x = 10'd1023; lim_y = 10'd1023; drift = DRIFT_UP;   end
				2: begin lim_x = 10'd5;    lim_y = 10'd7;    drift = DRIFT_DOWN; end
				3: begin
					lim_x = 10'($urandom_range(0, 1023));
					lim_y = 10'($urandom_range(0, 1023));
					drift = DRIFT_UP;
				end
				4: begin
					lim_x = 10'($urandom_range(0, 1023));
					lim_y = 10'($urandom_range(0, 1023));
					drift = DRIFT_ANY;
				end
				default: begin lim_x = X_LIMIT_RST; lim_y = Y_LIMIT_RST; drift = DRIFT_DOWN; end
			endcase
			pace <= (ph < 2) ? PACE_SINK_HEAVY : (ph < 4) ? PACE_SOURCE_HEAVY : PACE_FULL;
			write_limit(CFG_X_LIMIT, lim_x);
			write_limit(CFG_Y_LIMIT, lim_y);
			@(negedge clk);
			for (int n = 0; n < 85; n++) begin
				dir_x = ($urandom_range(0, 9) < 6) ? drift : DRIFT_ANY;
				dir_y = ($urandom_range(0, 9) < 6) ? drift : DRIFT_ANY;
				push_packet(8'($urandom_range(0, 255)), pick_motion(dir_x),
					pick_motion(dir_y));
				// stray byte now and then: shifts the framing of what follows
				if ($urandom_range(0, 19) == 0)
					push_byte(8'($urandom_range(0, 255)));
			end
			wait_drained();
		end

		if (expected_cursor.size() != 0)
			report_mismatch("cursor words never delivered", 0, expected_cursor.size());
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
